[rtl/clnw_pkg.sv]
// Package for the character-LCD nibble writer: request modes, flag bits,
// configuration and transfer-burst types. No dependencies.
package clnw_pkg;

  localparam int unsigned MaxColumnsDefault = 40;
  localparam int unsigned EffColW           = 7;
  localparam int unsigned MaxBeats          = 4;

  localparam logic [2:0] FlagDisplay = 3'b100;
  localparam logic [2:0] FlagCursor  = 3'b010;
  localparam logic [2:0] FlagBlink   = 3'b001;

  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdHome    = 8'h02;
  localparam logic [7:0] CmdControl = 8'h08;
  localparam logic [7:0] CmdAddress = 8'h80;
  localparam logic [7:0] AddrRow1   = 8'h40;

  typedef enum logic [3:0] {
    ModeChar     = 4'd0,
    ModeCommand  = 4'd1,
    ModePosition = 4'd2,
    ModeHome     = 4'd3,
    ModeClear    = 4'd4,
    ModeDisplay  = 4'd5,
    ModeCursor   = 4'd6,
    ModeBlink    = 4'd7,
    ModeNibble   = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    RegColumns = 2'd0,
    RegRows    = 2'd1,
    RegWideBus = 2'd2
  } reg_e;

  typedef struct packed {
    logic [5:0] columns_in_use;
    logic [2:0] rows_in_use;
    logic       wide_bus;
  } cfg_t;

  typedef struct packed {
    logic [MaxBeats-1:0]      rs;
    logic [MaxBeats-1:0][7:0] val;
    logic [2:0]               count;
    logic [5:0]               col;
    logic [1:0]               row;
  } burst_t;

endpackage

[rtl/clnw_if.sv]
// Valid/ready channel interfaces: LCD requests in, bus transfers out.
// Depends on nothing.
interface clnw_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] data_byte;
  logic [5:0] column;
  logic [1:0] row;
  logic       flag;

  modport source (output valid, mode, data_byte, column, row, flag, input ready);
  modport sink   (input valid, mode, data_byte, column, row, flag, output ready);
endinterface

interface clnw_xfer_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_value;
  logic       last;
  logic [5:0] cursor_column;
  logic [1:0] cursor_row;

  modport source (output valid, reg_select, bus_value, last, cursor_column, cursor_row,
                  input ready);
  modport sink   (input valid, reg_select, bus_value, last, cursor_column, cursor_row,
                  output ready);
endinterface

[rtl/clnw_decode.sv]
// Request decoder: turns one request into a burst of up to four transfers
// and holds the cursor and control flags. Depends on clnw_pkg.
module clnw_decode #(
  parameter int unsigned MaxColumns = clnw_pkg::MaxColumnsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [3:0]          mode_i,
  input  logic [7:0]          data_byte_i,
  input  logic [5:0]          column_i,
  input  logic [1:0]          row_i,
  input  logic                flag_i,
  input  clnw_pkg::cfg_t      cfg_i,
  output clnw_pkg::burst_t    burst_o
);
  import clnw_pkg::*;

  logic [5:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic [2:0] flags_q, flags_d;

  logic [EffColW-1:0] eff_cols;
  logic [2:0]         eff_rows;
  logic [EffColW-1:0] next_col;
  logic [2:0]         next_row;
  logic [1:0]         nbytes;
  logic [1:0]         b_rs;
  logic [1:0][7:0]    b_val;
  logic               raw;
  logic [2:0]         flag_bit;

  function automatic logic [7:0] addr_cmd(logic [5:0] col, logic [1:0] row);
    logic [7:0] base;
    base = (row != 2'd0) ? (CmdAddress | AddrRow1) : CmdAddress;
    return base + {2'b00, col};
  endfunction

  always_comb begin
    logic [EffColW-1:0] max_cols;
    max_cols = EffColW'(MaxColumns);
    eff_cols = ({1'b0, cfg_i.columns_in_use} < max_cols) ?
               {1'b0, cfg_i.columns_in_use} : max_cols;
    eff_rows = (cfg_i.rows_in_use < 3'd4) ? cfg_i.rows_in_use : 3'd4;
  end

  always_comb begin
    nbytes   = 2'd0;
    b_rs     = '0;
    b_val    = '0;
    raw      = 1'b0;
    col_d    = col_q;
    row_d    = row_q;
    flags_d  = flags_q;
    next_col = {1'b0, col_q} + EffColW'(1);
    next_row = {1'b0, row_q} + 3'd1;
    flag_bit = '0;
    case (mode_i)
      ModeChar: begin
        nbytes   = 2'd1;
        b_rs[0]  = 1'b1;
        b_val[0] = data_byte_i;
        if (next_col >= eff_cols) begin
          if (next_row >= eff_rows) begin
            next_row = '0;
          end
          col_d    = '0;
          row_d    = next_row[1:0];
          nbytes   = 2'd2;
          b_val[1] = addr_cmd(6'd0, next_row[1:0]);
        end else begin
          col_d = next_col[5:0];
        end
      end
      ModeCommand: begin
        nbytes   = 2'd1;
        b_val[0] = data_byte_i;
      end
      ModePosition: begin
        if (({1'b0, column_i} < eff_cols) && ({1'b0, row_i} < eff_rows)) begin
          nbytes   = 2'd1;
          b_val[0] = addr_cmd(column_i, row_i);
          col_d    = column_i;
          row_d    = row_i;
        end
      end
      ModeHome: begin
        nbytes   = 2'd1;
        b_val[0] = CmdHome;
        col_d    = '0;
        row_d    = '0;
      end
      ModeClear: begin
        nbytes   = 2'd2;
        b_val[0] = CmdClear;
        b_val[1] = CmdHome;
        col_d    = '0;
        row_d    = '0;
      end
      ModeDisplay, ModeCursor, ModeBlink: begin
        if (mode_i == ModeDisplay) begin
          flag_bit = FlagDisplay;
        end else if (mode_i == ModeCursor) begin
          flag_bit = FlagCursor;
        end else begin
          flag_bit = FlagBlink;
        end
        flags_d  = flag_i ? (flags_q | flag_bit) : (flags_q & ~flag_bit);
        nbytes   = 2'd1;
        b_val[0] = CmdControl | {5'd0, flags_d};
      end
      ModeNibble: begin
        raw = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    burst_o     = '0;
    burst_o.col = col_d;
    burst_o.row = row_d;
    if (raw) begin
      burst_o.val[0] = {4'h0, data_byte_i[3:0]};
      burst_o.count  = 3'd1;
    end else if (cfg_i.wide_bus) begin
      burst_o.rs[1:0]  = b_rs;
      burst_o.val[0]   = b_val[0];
      burst_o.val[1]   = b_val[1];
      burst_o.count    = {1'b0, nbytes};
    end else begin
      burst_o.rs     = {b_rs[1], b_rs[1], b_rs[0], b_rs[0]};
      burst_o.val[0] = {4'h0, b_val[0][7:4]};
      burst_o.val[1] = {4'h0, b_val[0][3:0]};
      burst_o.val[2] = {4'h0, b_val[1][7:4]};
      burst_o.val[3] = {4'h0, b_val[1][3:0]};
      burst_o.count  = {nbytes, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flags_q <= '0;
    end else if (accept_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      flags_q <= flags_d;
    end
  end

endmodule

[rtl/clnw_burst.sv]
// Burst register and output beat register: plays a decoded burst out one
// transfer per beat. Depends on clnw_pkg and clnw_if.
module clnw_burst (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  clnw_pkg::burst_t  burst_i,
  clnw_xfer_if.source       xfer
);
  import clnw_pkg::*;

  burst_t     burst_q;
  logic       bvalid_q, bvalid_d;
  logic [1:0] idx_q;
  logic       load;
  logic       beat_last;
  logic       accept;

  logic       ovalid_q;
  logic       rs_q;
  logic [7:0] val_q;
  logic       last_q;
  logic [5:0] col_q;
  logic [1:0] row_q;

  assign load       = bvalid_q && (!ovalid_q || xfer.ready);
  assign beat_last  = ({1'b0, idx_q} == (burst_q.count - 3'd1));
  assign in_ready_o = !bvalid_q || (load && beat_last);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    bvalid_d = bvalid_q && !(load && beat_last);
    if (accept && (burst_i.count != 3'd0)) begin
      bvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      bvalid_q <= bvalid_d;
      if (accept) begin
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (xfer.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      burst_q <= burst_i;
    end
    if (load) begin
      rs_q   <= burst_q.rs[idx_q];
      val_q  <= burst_q.val[idx_q];
      last_q <= beat_last;
      col_q  <= burst_q.col;
      row_q  <= burst_q.row;
    end
  end

  assign xfer.valid         = ovalid_q;
  assign xfer.reg_select    = rs_q;
  assign xfer.bus_value     = val_q;
  assign xfer.last          = last_q;
  assign xfer.cursor_column = col_q;
  assign xfer.cursor_row    = row_q;

`ifndef SYNTHESIS
  a_burst_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> (burst_q.count != 3'd0))
    else $error("empty burst held");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> ({1'b0, idx_q} < burst_q.count))
    else $error("beat index past burst");
  a_burst_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (burst_i.count != 3'd0)) |=> bvalid_q && (idx_q == 2'd0))
    else $error("burst not loaded");
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && beat_last) |=> (ovalid_q && last_q))
    else $error("final beat not marked last");
`endif

endmodule

[rtl/char_lcd_nibble_writer_unit.sv]
// Character-LCD nibble writer, top level: APB configuration registers,
// request decoder and transfer serializer. Depends on clnw_pkg, clnw_if,
// clnw_decode and clnw_burst.
// Usage:
//   req  (sink): one request beat per LCD operation (char, command,
//        position, home, clear, display/cursor/blink flag, raw nibble).
//   xfer (source): one beat per bus strobe, with register select, the
//        value for the data lines, a last marker and the cursor after the
//        request. A 4-bit bus sends two beats per byte, high nibble first.
//   APB: columns_in_use at 0x0, rows_in_use at 0x4, wide_bus at 0x8.
// Path: burst register, then output beat register, then xfer.
// Throughput: an item occupies the burst register until all of its
//   transfers (1 to 4) are loaded; while xfer.ready is high the output
//   port moves one transfer per cycle, so the sustained rate is set by the
//   transfer count of each request. Empty requests never enter the register.
// Reset: cursor at row 0 column 0, all control flags off, 16 columns,
//   2 rows, 4-bit bus; no transfers pending.
// Stall: while xfer.ready is low the output beat holds and one further
//   burst waits in the burst register; req.ready then drops.
module char_lcd_nibble_writer_unit #(
  parameter int unsigned MaxColumns = clnw_pkg::MaxColumnsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clnw_req_if.sink    req,
  clnw_xfer_if.source xfer,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clnw_pkg::*;

  cfg_t   cfg_q;
  burst_t burst;
  logic   in_ready;
  logic   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns_in_use <= 6'd16;
      cfg_q.rows_in_use    <= 3'd2;
      cfg_q.wide_bus       <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegColumns: cfg_q.columns_in_use <= pwdata[5:0];
        RegRows:    cfg_q.rows_in_use    <= pwdata[2:0];
        RegWideBus: cfg_q.wide_bus       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegColumns: prdata = {26'd0, cfg_q.columns_in_use};
      RegRows:    prdata = {29'd0, cfg_q.rows_in_use};
      RegWideBus: prdata = {31'd0, cfg_q.wide_bus};
      default:    prdata = '0;
    endcase
  end

  assign req.ready = in_ready;

  clnw_decode #(
    .MaxColumns (MaxColumns)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (req.valid && in_ready),
    .mode_i      (req.mode),
    .data_byte_i (req.data_byte),
    .column_i    (req.column),
    .row_i       (req.row),
    .flag_i      (req.flag),
    .cfg_i       (cfg_q),
    .burst_o     (burst)
  );

  clnw_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .burst_i    (burst),
    .xfer       (xfer)
  );

endmodule
